/* sv/ledbw_pkg.sv */
`timescale 1ns / 1ps

package ledbw_pkg;

	localparam int NumLeds = 128;
	localparam int LedCmpW = 11;

	localparam int IdxW    = 7;
	localparam int ChW     = 8;
	localparam int ModeW   = 2;
	localparam int CfgIdxW = 3;
	localparam int OffW    = 16;
	localparam int HW      = 8;
	localparam int H100W   = 15;
	localparam int SegW    = 16;
	localparam int XW      = 17;
	localparam int PW      = 15;
	localparam int PpW     = 2 * PW;
	localparam int NumW    = PpW + ChW;
	localparam int QW      = 8;
	localparam int DvSh    = QW - 1;
	localparam int CntW    = 5;

	localparam logic [ModeW-1:0] ModeNone    = 2'd0;
	localparam logic [ModeW-1:0] ModeBreathe = 2'd1;
	localparam logic [ModeW-1:0] ModeWave    = 2'd2;

	localparam logic CmdPixel = 1'b0;
	localparam logic CmdTick  = 1'b1;

	localparam logic [CfgIdxW-1:0] RegMode         = 3'd0;
	localparam logic [CfgIdxW-1:0] RegRed          = 3'd1;
	localparam logic [CfgIdxW-1:0] RegGreen        = 3'd2;
	localparam logic [CfgIdxW-1:0] RegBlue         = 3'd3;
	localparam logic [CfgIdxW-1:0] RegBreatheFloor = 3'd4;
	localparam logic [CfgIdxW-1:0] RegWaveFloor    = 3'd5;
	localparam logic [CfgIdxW-1:0] RegHalfLen      = 3'd6;

	localparam logic [ChW-1:0] BreatheTop = 8'd200;
	localparam logic [ChW-1:0] LevelReset = 8'd100;
	localparam logic [HW-1:0]  HalfReset  = 8'd8;
	localparam logic [ChW-1:0] LevelMax   = 8'd255;
	localparam logic [PpW-1:0] BreatheDen = 30'd40000;

	typedef enum logic [2:0] {
		StIdle,
		StMod,
		StMulP,
		StMulS,
		StDiv,
		StScale,
		StDone
	} state_t;

endpackage

/* sv/ledbw_pix_if.sv */
`timescale 1ns / 1ps

interface ledbw_pix_if import ledbw_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            command;
	logic [IdxW-1:0] led_index;

	modport source (output valid, output command, output led_index, input ready);
	modport sink (input valid, input command, input led_index, output ready);
endinterface

/* sv/ledbw_res_if.sv */
`timescale 1ns / 1ps

interface ledbw_res_if import ledbw_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [ChW-1:0] out_red;
	logic [ChW-1:0] out_green;
	logic [ChW-1:0] out_blue;
	logic [ChW-1:0] applied_level;

	modport source (
		output valid, output out_red, output out_green, output out_blue,
		output applied_level, input ready
	);
	modport sink (
		input valid, input out_red, input out_green, input out_blue,
		input applied_level, output ready
	);
endinterface

/* sv/ledbw_cfg_if.sv */
`timescale 1ns / 1ps

interface ledbw_cfg_if import ledbw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [ChW-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/led_breathe_wave_dimmer_unit.sv */
`timescale 1ns / 1ps
// channel | modport | moves
// pix     | sink    | command (pixel or tick) and led index
// res     | source  | scaled red, green, blue and applied level
// cfg     | sink    | register index and write data, always ready
//
// a tick is applied in the accepting cycle and gives no result
// a pixel in mode none goes straight to done; breathe runs shift-add multiply
// (phase squared, then times the span), quotient bits and shift-add channel
// scaling; wave adds a bit-serial modulo first; one shared serial datapath
// arst_n resets the control state, the effect phase and the registers
// one pixel at a time; a finished result waits in the output register while
// the next transaction is taken, and the datapath holds while res stalls

module led_breathe_wave_dimmer_unit import ledbw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ledbw_pix_if.sink    pix,
	ledbw_res_if.source  res,
	ledbw_cfg_if.sink    cfg
);

	state_t state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;

	logic [ModeW-1:0] mode_q;
	logic [ChW-1:0]   red_q, green_q, blue_q, bfloor_q, wfloor_q;
	logic [HW-1:0]    half_q;

	logic [ChW-1:0]  level_q;
	logic            rising_q;
	logic [OffW-1:0] offset_q;

	logic [XW-1:0]   xsh_q;
	logic [SegW-1:0] rem_q;
	logic [NumW-1:0] acc_q, mc_q, dv_q;
	logic [PW-1:0]   mp_q, dmp_q;
	logic [PpW-1:0]  dacc_q, dmc_q;
	logic [QW-1:0]   q_q;
	logic [ChW-1:0]  lvl_q, bsh_q;
	logic [2*ChW-1:0] racc_q, gacc_q, bacc_q;

	logic           res_valid_q;
	logic [ChW-1:0] res_red_q, res_green_q, res_blue_q, res_lvl_q;

	logic pix_ready, pix_acc, load_out, last_step, oob;

	logic [HW-1:0]    half_eff;
	logic [H100W-1:0] h100;
	logic [SegW-1:0]  seg;
	logic [XW-1:0]    x_val;
	logic [ChW-1:0]   floor_sel, span;

	logic            rising_n;
	logic [ChW-1:0]  level_n;
	logic [OffW-1:0] off_inc;

	logic [SegW:0]   r2, rnext;
	logic [SegW-1:0] p_fold;
	logic [NumW-1:0] acc_sum;
	logic [PpW-1:0]  dacc_sum;
	logic            div_ge;
	logic [QW-1:0]   q_next;
	logic [ChW:0]    bsum;
	logic [ChW-1:0]  b_val;
	logic [ChW:0]    rt, gt, bt;

	function automatic logic [CntW-1:0] phase_steps(state_t s);
		case (s)
			StMod:   phase_steps = CntW'(XW);
			StMulP:  phase_steps = CntW'(PW);
			StMulS:  phase_steps = CntW'(ChW);
			StDiv:   phase_steps = CntW'(QW);
			StScale: phase_steps = CntW'(ChW);
			default: phase_steps = '0;
		endcase
	endfunction

	assign cfg.ready = 1'b1;
	assign pix.ready = pix_ready;
	assign pix_acc   = pix.valid && pix_ready;
	assign last_step = (cnt_q == CntW'(1));
	assign oob       = LedCmpW'(pix.led_index) >= LedCmpW'(NumLeds);

	assign res.valid         = res_valid_q;
	assign res.out_red       = res_red_q;
	assign res.out_green     = res_green_q;
	assign res.out_blue      = res_blue_q;
	assign res.applied_level = res_lvl_q;

	// geometry of the wave
	assign half_eff = (half_q == '0) ? HW'(1) : half_q;
	assign h100 = H100W'({half_eff, 6'b0}) + H100W'({half_eff, 5'b0})
		+ H100W'({half_eff, 2'b0});
	assign seg = {h100, 1'b0};
	assign x_val = XW'({pix.led_index, 6'b0}) + XW'({pix.led_index, 5'b0})
		+ XW'({pix.led_index, 2'b0}) + XW'(offset_q);

	assign floor_sel = (mode_q == ModeBreathe) ? bfloor_q : wfloor_q;
	assign span      = LevelMax - floor_sel;

	// phase advance
	always_comb begin
		if (level_q >= BreatheTop) begin
			rising_n = 1'b0;
		end else if (level_q == '0) begin
			rising_n = 1'b1;
		end else begin
			rising_n = rising_q;
		end
		level_n = rising_n ? level_q + ChW'(1) : level_q - ChW'(1);
		off_inc = offset_q + OffW'(1);
	end

	// serial arithmetic steps
	always_comb begin
		r2     = {rem_q, xsh_q[XW-1]};
		rnext  = (r2 >= {1'b0, seg}) ? r2 - {1'b0, seg} : r2;
		p_fold = (rnext[SegW-1:0] > SegW'(h100)) ? seg - rnext[SegW-1:0]
			: rnext[SegW-1:0];
		acc_sum  = acc_q + (mp_q[0] ? mc_q : '0);
		dacc_sum = dacc_q + (dmp_q[0] ? dmc_q : '0);
		div_ge   = acc_q >= dv_q;
		q_next   = {q_q[QW-2:0], div_ge};
		bsum     = {1'b0, floor_sel} + (ChW+1)'(q_next);
		b_val    = bsum[ChW] ? LevelMax : bsum[ChW-1:0];
		rt = {1'b0, racc_q[2*ChW-1:ChW]} + (bsh_q[0] ? {1'b0, red_q} : '0);
		gt = {1'b0, gacc_q[2*ChW-1:ChW]} + (bsh_q[0] ? {1'b0, green_q} : '0);
		bt = {1'b0, bacc_q[2*ChW-1:ChW]} + (bsh_q[0] ? {1'b0, blue_q} : '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			StIdle: begin
				if (pix_acc && pix.command == CmdPixel) begin
					if (oob) begin
						state_d = StDone;
					end else if (mode_q == ModeBreathe) begin
						state_d = StMulP;
					end else if (mode_q == ModeWave) begin
						state_d = StMod;
					end else begin
						state_d = StDone;
					end
				end
			end
			StMod:   if (last_step) state_d = StMulP;
			StMulP:  if (last_step) state_d = StMulS;
			StMulS:  if (last_step) state_d = StDiv;
			StDiv:   if (last_step) state_d = StScale;
			StScale: if (last_step) state_d = StDone;
			StDone:  if (load_out) state_d = StIdle;
			default: state_d = StIdle;
		endcase
		cnt_d = (state_d != state_q) ? phase_steps(state_d) : cnt_q - CntW'(1);
	end

	// outputs of the state machine
	always_comb begin
		pix_ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			StIdle:  pix_ready = 1'b1;
			StDone:  load_out = !res_valid_q || res.ready;
			default: begin
				pix_ready = 1'b0;
				load_out  = 1'b0;
			end
		endcase
	end

	// control, phase and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			cnt_q       <= '0;
			mode_q      <= ModeNone;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			bfloor_q    <= '0;
			wfloor_q    <= '0;
			half_q      <= HalfReset;
			level_q     <= LevelReset;
			rising_q    <= 1'b1;
			offset_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg.valid) begin
				case (cfg.index)
					RegMode:         mode_q   <= cfg.data[ModeW-1:0];
					RegRed:          red_q    <= cfg.data;
					RegGreen:        green_q  <= cfg.data;
					RegBlue:         blue_q   <= cfg.data;
					RegBreatheFloor: bfloor_q <= cfg.data;
					RegWaveFloor:    wfloor_q <= cfg.data;
					RegHalfLen:      half_q   <= cfg.data;
					default:         ;
				endcase
			end
			if (pix_acc && pix.command == CmdTick) begin
				if (mode_q == ModeBreathe) begin
					rising_q <= rising_n;
					level_q  <= level_n;
				end else if (mode_q == ModeWave) begin
					offset_q <= (off_inc >= seg) ? '0 : off_inc;
				end
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// shared serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				xsh_q <= x_val;
				rem_q <= '0;
				acc_q <= '0;
				mc_q  <= NumW'(level_q);
				mp_q  <= PW'(level_q);
				dacc_q <= BreatheDen;
				dmc_q <= '0;
				dmp_q <= '0;
				if (oob) begin
					racc_q <= '0;
					gacc_q <= '0;
					bacc_q <= '0;
					lvl_q  <= '0;
				end else begin
					racc_q <= {red_q, ChW'(0)};
					gacc_q <= {green_q, ChW'(0)};
					bacc_q <= {blue_q, ChW'(0)};
					lvl_q  <= LevelMax;
				end
			end
			StMod: begin
				rem_q <= rnext[SegW-1:0];
				xsh_q <= {xsh_q[XW-2:0], 1'b0};
				if (last_step) begin
					acc_q  <= '0;
					mc_q   <= NumW'(p_fold[PW-1:0]);
					mp_q   <= p_fold[PW-1:0];
					dacc_q <= '0;
					dmc_q  <= PpW'(h100);
					dmp_q  <= PW'(h100);
				end
			end
			StMulP: begin
				dacc_q <= dacc_sum;
				dmc_q  <= {dmc_q[PpW-2:0], 1'b0};
				dmp_q  <= dmp_q >> 1;
				if (last_step) begin
					acc_q <= '0;
					mc_q  <= acc_sum;
					mp_q  <= PW'(span);
				end else begin
					acc_q <= acc_sum;
					mc_q  <= {mc_q[NumW-2:0], 1'b0};
					mp_q  <= mp_q >> 1;
				end
			end
			StMulS: begin
				acc_q <= acc_sum;
				mc_q  <= {mc_q[NumW-2:0], 1'b0};
				mp_q  <= mp_q >> 1;
				if (last_step) begin
					dv_q <= NumW'({dacc_q, DvSh'(0)});
					q_q  <= '0;
				end
			end
			StDiv: begin
				if (div_ge) begin
					acc_q <= acc_q - dv_q;
				end
				q_q  <= q_next;
				dv_q <= dv_q >> 1;
				if (last_step) begin
					lvl_q  <= b_val;
					bsh_q  <= b_val;
					racc_q <= '0;
					gacc_q <= '0;
					bacc_q <= '0;
				end
			end
			StScale: begin
				racc_q <= {rt, racc_q[ChW-1:1]};
				gacc_q <= {gt, gacc_q[ChW-1:1]};
				bacc_q <= {bt, bacc_q[ChW-1:1]};
				bsh_q  <= bsh_q >> 1;
			end
			StDone: begin
				if (load_out) begin
					res_red_q   <= racc_q[2*ChW-1:ChW];
					res_green_q <= gacc_q[2*ChW-1:ChW];
					res_blue_q  <= bacc_q[2*ChW-1:ChW];
					res_lvl_q   <= lvl_q;
				end
			end
			default: ;
		endcase
	end

endmodule

/* verif/tb_led_breathe_wave_dimmer_unit.sv */
`timescale 1ns / 1ps

module tb_led_breathe_wave_dimmer_unit;
	import ledbw_pkg::*;

	localparam logic [ModeW-1:0] ModeSpare = 2'd3;
	localparam int DrainCycles = 80;
	localparam int StallLimit  = 2000;

	typedef struct packed {
		logic            command;
		logic [IdxW-1:0] led_index;
	} strip_item_t;

	typedef struct packed {
		logic [ChW-1:0] red;
		logic [ChW-1:0] green;
		logic [ChW-1:0] blue;
		logic [ChW-1:0] level;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n;

	ledbw_pix_if pix ();
	ledbw_res_if res ();
	ledbw_cfg_if cfg ();

	led_breathe_wave_dimmer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	always begin
		#6;
		clk = 1'b1;
		#6;
		clk = 1'b0;
	end

	// register copies and effect phase
	logic [ModeW-1:0] reg_mode;
	logic [ChW-1:0]   reg_red;
	logic [ChW-1:0]   reg_green;
	logic [ChW-1:0]   reg_blue;
	logic [ChW-1:0]   reg_breathe_floor;
	logic [ChW-1:0]   reg_wave_floor;
	logic [HW-1:0]    reg_half_len;
	logic [ChW-1:0]   breathe_lvl;
	logic             breathe_up;
	logic [OffW-1:0]  wave_pos;

	strip_item_t strip_items[$];
	shade_t      shades_due[$];
	strip_item_t next_item;
	shade_t      got_shade;
	shade_t      want_shade;
	int          mismatches = 0;
	int          stall_cycles = 0;
	logic [15:0] cycle_count = '0;
	logic        calm;

	// no idling on either side in one window of every four
	assign calm = (cycle_count[12:11] == 2'b11);

	function automatic logic [ChW-1:0] scale_channel(logic [ChW-1:0] c, longint unsigned b);
		longint unsigned prod;
		prod = c * b;
		return prod[15:8];
	endfunction

	function automatic shade_t dim_pixel(logic [IdxW-1:0] idx);
		longint unsigned b;
		longint unsigned lv;
		longint unsigned span;
		longint unsigned h100;
		longint unsigned seg;
		longint unsigned p;
		shade_t s;
		if (idx >= NumLeds)
			return '0;
		if (reg_mode == ModeBreathe) begin
			lv = 64'(breathe_lvl);
			span = 64'(255 - reg_breathe_floor);
			b = reg_breathe_floor + (lv * lv * span) / BreatheDen;
		end else if (reg_mode == ModeWave) begin
			h100 = 64'(100 * ((reg_half_len == 0) ? 1 : reg_half_len));
			seg = 2 * h100;
			p = 64'(idx);
			p = (p * 100 + wave_pos) % seg;
			if (p > h100)
				p = seg - p;
			span = 64'(255 - reg_wave_floor);
			b = reg_wave_floor + (p * p * span) / (h100 * h100);
		end else begin
			s.red = reg_red;
			s.green = reg_green;
			s.blue = reg_blue;
			s.level = LevelMax;
			return s;
		end
		if (b > 255)
			b = 255;
		s.red = scale_channel(reg_red, b);
		s.green = scale_channel(reg_green, b);
		s.blue = scale_channel(reg_blue, b);
		s.level = b[7:0];
		return s;
	endfunction

	task automatic advance_effect();
		int seg;
		if (reg_mode == ModeBreathe) begin
			if (breathe_lvl >= BreatheTop)
				breathe_up = 1'b0;
			else if (breathe_lvl == 0)
				breathe_up = 1'b1;
			breathe_lvl = breathe_up ? breathe_lvl + 8'd1 : breathe_lvl - 8'd1;
		end else if (reg_mode == ModeWave) begin
			seg = 200 * ((reg_half_len == 0) ? 1 : reg_half_len);
			wave_pos = wave_pos + 16'd1;
			if (wave_pos >= seg)
				wave_pos = '0;
		end
	endtask

	task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [ChW-1:0] data);
		case (idx)
			RegMode: begin
				reg_mode = data[ModeW-1:0];
			end
			RegRed: begin
				reg_red = data;
			end
			RegGreen: begin
				reg_green = data;
			end
			RegBlue: begin
				reg_blue = data;
			end
			RegBreatheFloor: begin
				reg_breathe_floor = data;
			end
			RegWaveFloor: begin
				reg_wave_floor = data;
			end
			RegHalfLen: begin
				reg_half_len = data;
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(string what);
		mismatches++;
		if (mismatches <= 30)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic check_field(string name, logic [ChW-1:0] got, logic [ChW-1:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// pixel channel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.command <= CmdPixel;
			pix.led_index <= '0;
		end else begin
			if (pix.valid && pix.ready) begin
				if (pix.command == CmdTick)
					advance_effect();
				else
					shades_due.push_back(dim_pixel(pix.led_index));
			end
			if (!pix.valid || pix.ready) begin
				if (strip_items.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
					next_item = strip_items.pop_front();
					pix.valid <= 1'b1;
					pix.command <= next_item.command;
					pix.led_index <= next_item.led_index;
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				got_shade.red = res.out_red;
				got_shade.green = res.out_green;
				got_shade.blue = res.out_blue;
				got_shade.level = res.applied_level;
				if (shades_due.size() == 0) begin
					flag_mismatch("result transaction with nothing expected");
				end else begin
					want_shade = shades_due.pop_front();
					check_field("out_red", got_shade.red, want_shade.red);
					check_field("out_green", got_shade.green, want_shade.green);
					check_field("out_blue", got_shade.blue, want_shade.blue);
					check_field("applied_level", got_shade.level, want_shade.level);
				end
			end
			res.ready <= calm || ($urandom_range(0, 99) >= 8);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		cycle_count <= cycle_count + 16'd1;
		if (arst_n) begin
			if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic push_item(logic cmd, logic [IdxW-1:0] idx);
		strip_item_t it;
		it.command = cmd;
		it.led_index = idx;
		strip_items.push_back(it);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ChW-1:0] data);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do
			@(posedge clk);
		while (!(cfg.valid && cfg.ready));
		apply_reg(idx, data);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_colour(logic [ChW-1:0] r, logic [ChW-1:0] g, logic [ChW-1:0] b);
		write_reg(RegRed, r);
		write_reg(RegGreen, g);
		write_reg(RegBlue, b);
	endtask

	task automatic settle();
		while (strip_items.size() != 0 || pix.valid || shades_due.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic run_random(int count, int tick_pct, int lead_pixels);
		logic            cmd;
		logic [IdxW-1:0] idx;
		for (int k = 0; k < count; k++) begin
			cmd = (k >= lead_pixels && $urandom_range(0, 99) < tick_pct) ? CmdTick : CmdPixel;
			if ($urandom_range(0, 7) == 0)
				idx = $urandom_range(0, 1) ? {IdxW{1'b1}} : '0;
			else
				idx = IdxW'($urandom_range(0, NumLeds - 1));
			push_item(cmd, idx);
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.command = CmdPixel;
		pix.led_index = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = RegMode;
		cfg.data = '0;
		reg_mode = ModeNone;
		reg_red = '0;
		reg_green = '0;
		reg_blue = '0;
		reg_breathe_floor = '0;
		reg_wave_floor = '0;
		reg_half_len = HalfReset;
		breathe_lvl = LevelReset;
		breathe_up = 1'b1;
		wave_pos = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values, pass-through
		push_item(CmdPixel, 7'd0);
		push_item(CmdPixel, 7'd127);
		push_item(CmdTick, 7'd0);
		settle();

		// unused mode code behaves as no effect
		set_colour(8'd255, 8'd0, 8'd170);
		write_reg(RegMode, ChW'(ModeSpare));
		push_item(CmdPixel, 7'd127);
		push_item(CmdTick, 7'd127);
		push_item(CmdPixel, 7'd0);
		settle();

		write_reg(RegMode, ChW'(ModeBreathe));
		write_reg(RegBreatheFloor, 8'd0);
		push_item(CmdPixel, 7'd5);
		push_item(CmdTick, 7'd5);
		push_item(CmdPixel, 7'd5);
		settle();
		write_reg(RegBreatheFloor, 8'd255);
		push_item(CmdPixel, 7'd0);
		settle();

		// zero half length taken as one
		write_reg(RegMode, ChW'(ModeWave));
		write_reg(RegWaveFloor, 8'd0);
		write_reg(RegHalfLen, 8'd0);
		push_item(CmdPixel, 7'd0);
		push_item(CmdPixel, 7'd1);
		push_item(CmdPixel, 7'd127);
		push_item(CmdTick, 7'd64);
		push_item(CmdPixel, 7'd0);
		push_item(CmdPixel, 7'd1);
		settle();
		write_reg(RegWaveFloor, 8'd255);
		write_reg(RegHalfLen, 8'd255);
		push_item(CmdPixel, 7'd127);
		push_item(CmdPixel, 7'd0);
		settle();
		write_reg(RegWaveFloor, 8'd128);
		write_reg(RegHalfLen, 8'd1);
		push_item(CmdPixel, 7'd64);
		push_item(CmdTick, 7'd64);
		push_item(CmdPixel, 7'd64);
		settle();
		write_reg(RegMode, ChW'(ModeNone));
		set_colour(8'd255, 8'd255, 8'd255);
		push_item(CmdPixel, 7'd127);
		settle();

		set_colour(ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)),
			ChW'($urandom_range(0, 255)));
		run_random(100, 30, 0);

		// long breathe run to bounce off both ends
		write_reg(RegMode, ChW'(ModeBreathe));
		write_reg(RegBreatheFloor, ChW'($urandom_range(0, 255)));
		set_colour(ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)),
			ChW'($urandom_range(0, 255)));
		run_random(500, 65, 0);
		write_reg(RegBreatheFloor, 8'd255);
		set_colour(8'd255, 8'd255, 8'd255);
		run_random(60, 40, 0);

		// short segment, so the offset wraps
		write_reg(RegMode, ChW'(ModeWave));
		write_reg(RegHalfLen, 8'd1);
		write_reg(RegWaveFloor, 8'd0);
		set_colour(ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)),
			ChW'($urandom_range(0, 255)));
		run_random(350, 60, 0);

		// grow the offset past a short segment, then shrink the segment below it
		write_reg(RegHalfLen, 8'd255);
		write_reg(RegWaveFloor, ChW'($urandom_range(0, 255)));
		run_random(300, 90, 0);
		write_reg(RegHalfLen, 8'd1);
		run_random(45, 20, 6);

		write_reg(RegHalfLen, ChW'($urandom_range(2, 20)));
		write_reg(RegWaveFloor, ChW'($urandom_range(0, 255)));
		set_colour(ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)),
			ChW'($urandom_range(0, 255)));
		run_random(200, 40, 0);

		write_reg(RegMode, ChW'(ModeSpare));
		run_random(60, 30, 0);

		write_reg(RegMode, ChW'(ModeWave));
		write_reg(RegHalfLen, 8'd0);
		write_reg(RegWaveFloor, ChW'($urandom_range(0, 255)));
		set_colour(ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)),
			ChW'($urandom_range(0, 255)));
		run_random(100, 50, 0);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* led_breathe_wave_dimmer_unit.f */
sv/ledbw_pkg.sv
sv/ledbw_pix_if.sv
sv/ledbw_res_if.sv
sv/ledbw_cfg_if.sv
sv/led_breathe_wave_dimmer_unit.sv
verif/tb_led_breathe_wave_dimmer_unit.sv
